// ===== hw/rtl/flicd_pkg.sv =====
// ----------------------------------------------------------------------------
// flicd_pkg
// Shared types, constants and helper functions of the FLIC chunk decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package flicd_pkg;

    // chunk type codes
    localparam logic [15:0] CHUNK_PAL256  = 16'd4;
    localparam logic [15:0] CHUNK_PAL64   = 16'd11;
    localparam logic [15:0] CHUNK_DELTA   = 16'd12;
    localparam logic [15:0] CHUNK_BYTERUN = 16'd15;

    // write kinds
    localparam logic WRITE_PIXEL   = 1'b0;
    localparam logic WRITE_PALETTE = 1'b1;

    // chunk variant kept in component_index outside colour decoding
    localparam logic [1:0] VARIANT_PLAIN = 2'd0;
    localparam logic [1:0] VARIANT_ALT   = 2'd1;

    // bytes of a full 256-entry palette set, three per colour
    localparam logic [9:0] PAL_FULL_BYTES = 10'd768;

    localparam logic [8:0] FRAME_HEIGHT_RESET = 9'd192;

    typedef enum logic [15:0] {
        PH_IDLE    = 16'h0001,
        PH_PCNT_LO = 16'h0002,
        PH_PCNT_HI = 16'h0004,
        PH_PSKIP   = 16'h0008,
        PH_PSET    = 16'h0010,
        PH_COL256  = 16'h0020,
        PH_COL64   = 16'h0040,
        PH_DST_LO  = 16'h0080,
        PH_DST_HI  = 16'h0100,
        PH_DCNT_LO = 16'h0200,
        PH_DCNT_HI = 16'h0400,
        PH_NPKT    = 16'h0800,
        PH_DSKIP   = 16'h1000,
        PH_SIZE    = 16'h2000,
        PH_RUNVAL  = 16'h4000,
        PH_LITERAL = 16'h8000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [15:0] current_line;
        logic [15:0] lines_remaining;
        logic [15:0] packets_remaining;
        logic [9:0]  bytes_remaining;
        logic [15:0] pixel_pointer;
        logic [7:0]  palette_pointer;
        logic [8:0]  colour_accumulator;
        logic [1:0]  component_index;
        logic [7:0]  header_low_byte;
    } dec_state_t;

    typedef struct packed {
        logic        valid;
        logic        kind;
        logic [15:0] address;
        logic [8:0]  value;
        logic [7:0]  repeat_count;
    } dec_cmd_t;

    localparam dec_state_t DEC_STATE_RESET = '{
        phase:              PH_IDLE,
        current_line:       16'd0,
        lines_remaining:    16'd0,
        packets_remaining:  16'd0,
        bytes_remaining:    10'd0,
        pixel_pointer:      16'd0,
        palette_pointer:    8'd0,
        colour_accumulator: 9'd0,
        component_index:    2'd0,
        header_low_byte:    8'd0
    };

    function automatic dec_state_t end_line(input dec_state_t st);
        dec_state_t s;
        s = st;
        s.current_line    = s.current_line + 16'd1;
        s.lines_remaining = s.lines_remaining - 16'd1;
        s.phase           = (s.lines_remaining == 16'd0) ? PH_IDLE : PH_NPKT;
        return s;
    endfunction

    function automatic dec_state_t end_packet(input dec_state_t st);
        dec_state_t s;
        s = st;
        s.packets_remaining = s.packets_remaining - 16'd1;
        if (s.packets_remaining == 16'd0)
        begin
            s = end_line(s);
        end
        else
        begin
            s.phase = (s.component_index == VARIANT_ALT) ? PH_DSKIP : PH_SIZE;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/flic_chunk_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// flic_chunk_decoder_unit
// Decodes FLIC chunk payload bytes into framebuffer and palette write commands.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake             payload
// byte      in         byte_valid/byte_stall chunk_type, chunk_start, data_byte
// cmd       out        cmd_valid/cmd_stall   write_kind, target_address,
//                                            write_value, repeat_count
// cfg       in         cfg_write_en          cfg_write_data (frame_height)
//
// one byte per cycle while no command stalls; a taken byte is held in the byte
// register, then decoded into the command register (byte register, then decode)
// reset puts the decoder in the waiting-for-chunk-start phase and
// frame_height at 192
// a stalled command holds the decode step; a byte waiting in the byte
// register then raises byte_stall in the same cycle
//
`default_nettype none

module flic_chunk_decoder_unit #(
    parameter int LINE_STRIDE = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [8:0]  cfg_write_data,

    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [15:0] chunk_type,
    input  logic        chunk_start,
    input  logic [7:0]  data_byte,

    output logic        cmd_valid,
    input  logic        cmd_stall,
    output logic        write_kind,
    output logic [15:0] target_address,
    output logic [8:0]  write_value,
    output logic [7:0]  repeat_count
);
    import flicd_pkg::*;

    logic [8:0]  height_reg;
    logic        byte_valid_reg;
    logic [15:0] chunk_type_reg;
    logic        chunk_start_reg;
    logic [7:0]  data_byte_reg;
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_cmd_t    dec_cmd;
    logic        cmd_valid_reg;
    logic        write_kind_reg;
    logic [15:0] target_address_reg;
    logic [8:0]  write_value_reg;
    logic [7:0]  repeat_count_reg;
    logic        advance;
    logic        byte_take;

    // decode step runs when the command register is free or being emptied
    assign advance    = byte_valid_reg && (!cmd_valid_reg || !cmd_stall);
    assign byte_stall = byte_valid_reg && !advance;
    assign byte_take  = byte_valid && !byte_stall;

    flicd_decode #(
        .LINE_STRIDE (LINE_STRIDE)
    ) u_decode (
        .cur_state    (state_reg),
        .frame_height (height_reg),
        .chunk_type   (chunk_type_reg),
        .chunk_start  (chunk_start_reg),
        .data_byte    (data_byte_reg),
        .next_state   (state_next),
        .cmd          (dec_cmd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg <= FRAME_HEIGHT_RESET;
        end
        else if (cfg_write_en)
        begin
            height_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
        end
        else if (byte_take)
        begin
            byte_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            byte_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            chunk_type_reg  <= chunk_type;
            chunk_start_reg <= chunk_start;
            data_byte_reg   <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DEC_STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else if (advance && dec_cmd.valid)
        begin
            cmd_valid_reg <= 1'b1;
        end
        else if (!cmd_stall)
        begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && dec_cmd.valid)
        begin
            write_kind_reg     <= dec_cmd.kind;
            target_address_reg <= dec_cmd.address;
            write_value_reg    <= dec_cmd.value;
            repeat_count_reg   <= dec_cmd.repeat_count;
        end
    end

    assign cmd_valid      = cmd_valid_reg;
    assign write_kind     = write_kind_reg;
    assign target_address = target_address_reg;
    assign write_value    = write_value_reg;
    assign repeat_count   = repeat_count_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/flicd_decode.sv =====
// ----------------------------------------------------------------------------
// flicd_decode
// Next-state and command logic for one payload byte of a FLIC chunk.
// ----------------------------------------------------------------------------
`default_nettype none

module flicd_decode #(
    parameter int LINE_STRIDE = 256
) (
    input  flicd_pkg::dec_state_t cur_state,
    input  logic [8:0]            frame_height,
    input  logic [15:0]           chunk_type,
    input  logic                  chunk_start,
    input  logic [7:0]            data_byte,
    output flicd_pkg::dec_state_t next_state,
    output flicd_pkg::dec_cmd_t   cmd
);
    import flicd_pkg::*;

    dec_state_t  s;
    logic        deep;
    logic [2:0]  comp;
    logic [2:0]  ci;
    logic        neg;
    logic [7:0]  mag;
    logic [31:0] line_offset;

    always_comb
    begin
        s           = cur_state;
        cmd         = '0;
        deep        = 1'b0;
        comp        = 3'd0;
        ci          = 3'd0;
        neg         = 1'b0;
        mag         = 8'd0;
        line_offset = 32'd0;

        // first byte of a chunk restarts the decoder and selects the variant
        if (chunk_start)
        begin
            s = DEC_STATE_RESET;
            if (chunk_type == CHUNK_PAL256 || chunk_type == CHUNK_PAL64)
            begin
                s.component_index = (chunk_type == CHUNK_PAL64) ? VARIANT_ALT
                                                                : VARIANT_PLAIN;
                s.phase = PH_PCNT_LO;
            end
            else if (chunk_type == CHUNK_DELTA)
            begin
                s.component_index = VARIANT_ALT;
                s.phase           = PH_DST_LO;
            end
            else if (chunk_type == CHUNK_BYTERUN)
            begin
                s.lines_remaining = {7'd0, frame_height};
                s.phase = (frame_height == 9'd0) ? PH_IDLE : PH_NPKT;
            end
        end

        case (s.phase)
            PH_PCNT_LO:
            begin
                s.header_low_byte = data_byte;
                s.phase           = PH_PCNT_HI;
            end
            PH_PCNT_HI:
            begin
                s.packets_remaining = {data_byte, s.header_low_byte};
                s.phase = (s.packets_remaining == 16'd0) ? PH_IDLE : PH_PSKIP;
            end
            PH_PSKIP:
            begin
                s.palette_pointer = s.palette_pointer + data_byte;
                s.phase           = PH_PSET;
            end
            PH_PSET:
            begin
                s.bytes_remaining = (data_byte == 8'd0) ? PAL_FULL_BYTES
                                  : ({2'd0, data_byte} + {1'b0, data_byte, 1'b0});
                s.colour_accumulator = 9'd0;
                s.phase = (s.component_index == VARIANT_ALT) ? PH_COL64 : PH_COL256;
                s.component_index = 2'd0;
            end
            PH_COL256, PH_COL64:
            begin
                deep = (s.phase == PH_COL64);
                comp = deep ? data_byte[5:3] : data_byte[7:5];
                ci   = {1'b0, s.component_index} + 3'd1;
                s.colour_accumulator = {s.colour_accumulator[5:0], comp};
                s.bytes_remaining    = s.bytes_remaining - 10'd1;
                if (ci >= 3'd3)
                begin
                    cmd.valid        = 1'b1;
                    cmd.kind         = WRITE_PALETTE;
                    cmd.address      = {8'd0, s.palette_pointer};
                    cmd.value        = s.colour_accumulator;
                    cmd.repeat_count = 8'd1;
                    s.palette_pointer    = s.palette_pointer + 8'd1;
                    s.colour_accumulator = 9'd0;
                    ci = 3'd0;
                end
                s.component_index = ci[1:0];
                if (s.bytes_remaining == 10'd0)
                begin
                    s.component_index   = deep ? VARIANT_ALT : VARIANT_PLAIN;
                    s.packets_remaining = s.packets_remaining - 16'd1;
                    s.phase = (s.packets_remaining == 16'd0) ? PH_IDLE : PH_PSKIP;
                end
            end
            PH_DST_LO:
            begin
                s.header_low_byte = data_byte;
                s.phase           = PH_DST_HI;
            end
            PH_DST_HI:
            begin
                s.current_line = {data_byte, s.header_low_byte};
                s.phase        = PH_DCNT_LO;
            end
            PH_DCNT_LO:
            begin
                s.header_low_byte = data_byte;
                s.phase           = PH_DCNT_HI;
            end
            PH_DCNT_HI:
            begin
                s.lines_remaining = {data_byte, s.header_low_byte};
                s.phase = (s.lines_remaining == 16'd0) ? PH_IDLE : PH_NPKT;
            end
            PH_NPKT:
            begin
                s.packets_remaining = {8'd0, data_byte};
                line_offset     = 32'(s.current_line) * 32'(LINE_STRIDE);
                s.pixel_pointer = line_offset[15:0];
                if (data_byte == 8'd0)
                begin
                    s = end_line(s);
                end
                else
                begin
                    s.phase = (s.component_index == VARIANT_ALT) ? PH_DSKIP : PH_SIZE;
                end
            end
            PH_DSKIP:
            begin
                s.pixel_pointer = s.pixel_pointer + {8'd0, data_byte};
                s.phase         = PH_SIZE;
            end
            PH_SIZE:
            begin
                // negative size is a run in delta chunks, a literal in byte-run
                neg = data_byte[7];
                mag = neg ? (8'd0 - data_byte) : data_byte;
                s.bytes_remaining = {2'd0, mag};
                if (s.component_index == VARIANT_ALT)
                begin
                    if (neg)
                    begin
                        s.phase = PH_RUNVAL;
                    end
                    else if (mag == 8'd0)
                    begin
                        s = end_packet(s);
                    end
                    else
                    begin
                        s.phase = PH_LITERAL;
                    end
                end
                else
                begin
                    s.phase = neg ? PH_LITERAL : PH_RUNVAL;
                end
            end
            PH_RUNVAL:
            begin
                if (s.bytes_remaining != 10'd0)
                begin
                    cmd.valid        = 1'b1;
                    cmd.kind         = WRITE_PIXEL;
                    cmd.address      = s.pixel_pointer;
                    cmd.value        = {1'b0, data_byte};
                    cmd.repeat_count = s.bytes_remaining[7:0];
                    s.pixel_pointer  = s.pixel_pointer + {6'd0, s.bytes_remaining};
                end
                s.bytes_remaining = 10'd0;
                s = end_packet(s);
            end
            PH_LITERAL:
            begin
                cmd.valid         = 1'b1;
                cmd.kind          = WRITE_PIXEL;
                cmd.address       = s.pixel_pointer;
                cmd.value         = {1'b0, data_byte};
                cmd.repeat_count  = 8'd1;
                s.pixel_pointer   = s.pixel_pointer + 16'd1;
                s.bytes_remaining = s.bytes_remaining - 10'd1;
                if (s.bytes_remaining == 10'd0)
                begin
                    s = end_packet(s);
                end
            end
            default:
            begin
                s = s;
            end
        endcase

        next_state = s;
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds directed and random FLIC chunk payloads into the chunk decoder and
// checks every write command against an in-bench decoder, across several
// frame heights and idle/stall mixes.
// ----------------------------------------------------------------------------

module testbench;
    import flicd_pkg::*;

    localparam int STRIDE          = 256;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_CYCLES     = 300;
    localparam int NUM_PHASES      = 6;

    typedef struct packed {
        logic [15:0] ctype;
        logic        first;
        logic [7:0]  data;
    } chunk_byte_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [8:0]  value;
        logic [7:0]  reps;
    } write_cmd_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [8:0]  cfg_write_data;
    logic        byte_valid;
    logic        byte_stall;
    logic [15:0] chunk_type;
    logic        chunk_start;
    logic [7:0]  data_byte;
    logic        cmd_valid;
    logic        cmd_stall;
    logic        write_kind;
    logic [15:0] target_address;
    logic [8:0]  write_value;
    logic [7:0]  repeat_count;

    chunk_byte_t byte_queue[$];
    write_cmd_t  pending_writes[$];

    int errors        = 0;
    int cycles        = 0;
    int pushed        = 0;
    int work_items    = 0;
    int bytes_offered = 0;
    int bytes_taken   = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_left     = 0;

    // stimulus builder state
    logic [15:0] gen_type;
    bit          gen_first;
    bit          gen_counts;

    // in-bench decoder state
    logic [8:0]  cfg_height;
    phase_t      dec_phase;
    logic [15:0] dec_line;
    logic [15:0] dec_lines;
    logic [15:0] dec_packets;
    logic [9:0]  dec_count;
    logic [15:0] dec_pix;
    logic [7:0]  dec_pal;
    logic [8:0]  dec_colour;
    logic [1:0]  dec_variant;
    logic [7:0]  dec_low;

    flic_chunk_decoder_unit #(
        .LINE_STRIDE(STRIDE)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .byte_valid     (byte_valid),
        .byte_stall     (byte_stall),
        .chunk_type     (chunk_type),
        .chunk_start    (chunk_start),
        .data_byte      (data_byte),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .write_kind     (write_kind),
        .target_address (target_address),
        .write_value    (write_value),
        .repeat_count   (repeat_count)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------
    function automatic void clear_decoder();
        dec_phase   = PH_IDLE;
        dec_line    = '0;
        dec_lines   = '0;
        dec_packets = '0;
        dec_count   = '0;
        dec_pix     = '0;
        dec_pal     = '0;
        dec_colour  = '0;
        dec_variant = VARIANT_PLAIN;
        dec_low     = '0;
    endfunction

    function automatic void line_done();
        dec_line  = dec_line + 16'd1;
        dec_lines = dec_lines - 16'd1;
        dec_phase = (dec_lines == 16'd0) ? PH_IDLE : PH_NPKT;
    endfunction

    function automatic void packet_done();
        dec_packets = dec_packets - 16'd1;
        if (dec_packets == 16'd0)
            line_done();
        else
            dec_phase = (dec_variant == VARIANT_ALT) ? PH_DSKIP : PH_SIZE;
    endfunction

    function automatic bit decode_byte(input chunk_byte_t in, output write_cmd_t cmd);
        logic [7:0] b;
        logic [2:0] comp;
        logic [2:0] ci;
        logic [8:0] mag;
        bit         deep;
        bit         hit;
        b   = in.data;
        hit = 1'b0;
        cmd = '0;
        if (in.first)
        begin
            clear_decoder();
            case (in.ctype)
                CHUNK_PAL256, CHUNK_PAL64:
                begin
                    dec_variant = (in.ctype == CHUNK_PAL64) ? VARIANT_ALT : VARIANT_PLAIN;
                    dec_phase   = PH_PCNT_LO;
                end
                CHUNK_DELTA:
                begin
                    dec_variant = VARIANT_ALT;
                    dec_phase   = PH_DST_LO;
                end
                CHUNK_BYTERUN:
                begin
                    dec_lines = {7'd0, cfg_height};
                    dec_phase = (cfg_height == 9'd0) ? PH_IDLE : PH_NPKT;
                end
                default: ;
            endcase
        end
        case (dec_phase)
            PH_PCNT_LO:
            begin
                dec_low   = b;
                dec_phase = PH_PCNT_HI;
            end
            PH_PCNT_HI:
            begin
                dec_packets = {b, dec_low};
                dec_phase   = (dec_packets == 16'd0) ? PH_IDLE : PH_PSKIP;
            end
            PH_PSKIP:
            begin
                // skip accumulates across packets
                dec_pal   = dec_pal + b;
                dec_phase = PH_PSET;
            end
            PH_PSET:
            begin
                dec_count   = (b == 8'd0) ? PAL_FULL_BYTES : {2'd0, b} * 10'd3;
                dec_colour  = '0;
                dec_phase   = (dec_variant == VARIANT_ALT) ? PH_COL64 : PH_COL256;
                dec_variant = VARIANT_PLAIN;
            end
            PH_COL256, PH_COL64:
            begin
                deep       = (dec_phase == PH_COL64);
                comp       = deep ? b[5:3] : b[7:5];
                ci         = {1'b0, dec_variant} + 3'd1;
                dec_colour = {dec_colour[5:0], comp};
                dec_count  = dec_count - 10'd1;
                if (ci >= 3'd3)
                begin
                    cmd        = '{WRITE_PALETTE, {8'd0, dec_pal}, dec_colour, 8'd1};
                    hit        = 1'b1;
                    dec_pal    = dec_pal + 8'd1;
                    dec_colour = '0;
                    ci         = 3'd0;
                end
                dec_variant = ci[1:0];
                if (dec_count == 10'd0)
                begin
                    dec_variant = deep ? VARIANT_ALT : VARIANT_PLAIN;
                    dec_packets = dec_packets - 16'd1;
                    dec_phase   = (dec_packets == 16'd0) ? PH_IDLE : PH_PSKIP;
                end
            end
            PH_DST_LO:
            begin
                dec_low   = b;
                dec_phase = PH_DST_HI;
            end
            PH_DST_HI:
            begin
                dec_line  = {b, dec_low};
                dec_phase = PH_DCNT_LO;
            end
            PH_DCNT_LO:
            begin
                dec_low   = b;
                dec_phase = PH_DCNT_HI;
            end
            PH_DCNT_HI:
            begin
                dec_lines = {b, dec_low};
                dec_phase = (dec_lines == 16'd0) ? PH_IDLE : PH_NPKT;
            end
            PH_NPKT:
            begin
                dec_packets = {8'd0, b};
                dec_pix     = 16'(32'(dec_line) * STRIDE);
                if (b == 8'd0)
                    line_done();
                else
                    dec_phase = (dec_variant == VARIANT_ALT) ? PH_DSKIP : PH_SIZE;
            end
            PH_DSKIP:
            begin
                dec_pix   = dec_pix + {8'd0, b};
                dec_phase = PH_SIZE;
            end
            PH_SIZE:
            begin
                mag       = b[7] ? (9'd256 - {1'b0, b}) : {1'b0, b};
                dec_count = {1'b0, mag};
                if (dec_variant == VARIANT_ALT)
                begin
                    if (b[7])
                        dec_phase = PH_RUNVAL;
                    else if (mag == 9'd0)
                        packet_done();
                    else
                        dec_phase = PH_LITERAL;
                end
                else
                    dec_phase = b[7] ? PH_LITERAL : PH_RUNVAL;
            end
            PH_RUNVAL:
            begin
                if (dec_count != 10'd0)
                begin
                    cmd     = '{WRITE_PIXEL, dec_pix, {1'b0, b}, dec_count[7:0]};
                    hit     = 1'b1;
                    dec_pix = dec_pix + {6'd0, dec_count};
                end
                dec_count = '0;
                packet_done();
            end
            PH_LITERAL:
            begin
                cmd       = '{WRITE_PIXEL, dec_pix, {1'b0, b}, 8'd1};
                hit       = 1'b1;
                dec_pix   = dec_pix + 16'd1;
                dec_count = dec_count - 10'd1;
                if (dec_count == 10'd0)
                    packet_done();
            end
            default: ;
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // sampling at the rising edge: register writes, requests, commands
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        write_cmd_t  want;
        write_cmd_t  got;
        chunk_byte_t took;
        if (rst_n)
        begin
            if (cfg_write_en)
                cfg_height = cfg_write_data;
            if (byte_valid && !byte_stall)
            begin
                took = '{chunk_type, chunk_start, data_byte};
                if (decode_byte(took, want))
                    pending_writes.push_back(want);
                bytes_taken++;
            end
            if (cmd_valid && !cmd_stall)
            begin
                got = '{write_kind, target_address, write_value, repeat_count};
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected command: kind %0h addr %0h value %0h count %0d",
                           got.kind, got.addr, got.value, got.reps);
                    errors++;
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (got.kind !== want.kind)
                    begin
                        $error("write_kind expected %0h actual %0h", want.kind, got.kind);
                        errors++;
                    end
                    if (got.addr !== want.addr)
                    begin
                        $error("target_address expected %0h actual %0h", want.addr, got.addr);
                        errors++;
                    end
                    if (got.value !== want.value)
                    begin
                        $error("write_value expected %0h actual %0h", want.value, got.value);
                        errors++;
                    end
                    if (got.reps !== want.reps)
                    begin
                        $error("repeat_count expected %0d actual %0d", want.reps, got.reps);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // byte driver and command receiver, both on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        chunk_byte_t nxt;
        // a new request goes out only once the previous one was taken
        if (bytes_offered == bytes_taken)
        begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = byte_queue.pop_front();
                byte_valid  <= 1'b1;
                chunk_type  <= nxt.ctype;
                chunk_start <= nxt.first;
                data_byte   <= nxt.data;
                bytes_offered++;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            cmd_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            cmd_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic open_chunk(input logic [15:0] ct);
        gen_type   = ct;
        gen_first  = 1'b1;
        gen_counts = 1'b1;
    endtask

    task automatic put(input logic [7:0] d);
        byte_queue.push_back('{gen_type, gen_first, d});
        gen_first = 1'b0;
        pushed++;
        if (gen_counts)
            work_items++;
    endtask

    task automatic put_word(input logic [15:0] w);
        put(w[7:0]);
        put(w[15:8]);
    endtask

    task automatic push_seq(input logic [15:0] ct, input int n, input logic [127:0] seq);
        open_chunk(ct);
        for (int i = n - 1; i >= 0; i--)
            put(seq[8*i +: 8]);
    endtask

    function automatic logic [15:0] pick_type();
        case ($urandom_range(3))
            0: return CHUNK_PAL256;
            1: return CHUNK_PAL64;
            2: return CHUNK_DELTA;
            default: return CHUNK_BYTERUN;
        endcase
    endfunction

    task automatic gen_palette(input logic [15:0] ct, input bit full);
        int npk;
        int nc;
        npk = ($urandom_range(15) == 0) ? 0 : $urandom_range(1, 3);
        if (full)
            npk = 1;
        open_chunk(ct);
        put_word(16'(npk));
        for (int p = 0; p < npk; p++)
        begin
            put(8'($urandom_range(255)));
            nc = full ? 256 : $urandom_range(1, 4);
            put(8'(nc));
            for (int k = 0; k < 3 * nc; k++)
                put(8'($urandom_range(255)));
        end
    endtask

    task automatic gen_line(input bit delta, input bit big);
        int npk;
        int sz;
        int mag;
        bit neg;
        if (big)
            npk = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        else
            npk = $urandom_range(0, 3);
        put(8'(npk));
        for (int p = 0; p < npk; p++)
        begin
            if (delta)
                put(8'($urandom_range(255)));
            if ($urandom_range(39) == 0)
                sz = $urandom_range(255);
            else if ($urandom_range(7) == 0)
                sz = 0;
            else
            begin
                mag = $urandom_range(1, 4);
                sz  = $urandom_range(1) ? 256 - mag : mag;
            end
            put(8'(sz));
            neg = (sz >= 128);
            mag = neg ? 256 - sz : sz;
            // negative size is a run in delta chunks, a literal in byte-run chunks
            if (delta ? neg : !neg)
                put(8'($urandom_range(255)));
            else
                for (int k = 0; k < mag; k++)
                    put(8'($urandom_range(255)));
        end
    endtask

    task automatic gen_delta();
        int          nl;
        logic [15:0] first_line;
        first_line = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                              : 16'($urandom_range(3));
        nl = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 3);
        open_chunk(CHUNK_DELTA);
        put_word(first_line);
        put_word(16'(nl));
        for (int l = 0; l < nl; l++)
            gen_line(1'b1, 1'b0);
    endtask

    task automatic gen_byterun();
        open_chunk(CHUNK_BYTERUN);
        // zero height: the first byte is dropped
        if (cfg_height == 9'd0)
            put(8'($urandom_range(255)));
        for (int l = 0; l < cfg_height; l++)
            gen_line(1'b0, cfg_height > 9'd16);
    endtask

    task automatic gen_noise();
        int          n;
        logic [15:0] ct;
        n = $urandom_range(1, 6);
        case ($urandom_range(2))
            0:
            begin
                ct = 16'($urandom_range(65535));
                if (ct == CHUNK_PAL256 || ct == CHUNK_PAL64 || ct == CHUNK_DELTA ||
                    ct == CHUNK_BYTERUN)
                    ct = ct ^ 16'h8000;
                open_chunk(ct);
                gen_counts = 1'b0;
                for (int k = 0; k < n; k++)
                    put(8'($urandom_range(255)));
            end
            1:
            begin
                // chunk cut short by whatever starts next
                open_chunk(pick_type());
                for (int k = 0; k < n; k++)
                    put(8'($urandom_range(255)));
            end
            default:
            begin
                gen_counts = 1'b0;
                for (int k = 0; k < n; k++)
                begin
                    gen_type  = $urandom_range(1) ? pick_type() : 16'($urandom_range(65535));
                    gen_first = ($urandom_range(3) == 0);
                    put(8'($urandom_range(255)));
                end
            end
        endcase
    endtask

    task automatic gen_random_chunk();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            gen_palette((r < 12) ? CHUNK_PAL256 : CHUNK_PAL64, 1'b0);
        else if (r < 55)
            gen_delta();
        else if (r < 75)
        begin
            if (cfg_height <= 9'd16 || $urandom_range(7) == 0)
                gen_byterun();
            else
                gen_delta();
        end
        else
            gen_noise();
        // stray bytes past the end of a chunk
        if ($urandom_range(7) == 0)
        begin
            gen_counts = 1'b0;
            for (int k = $urandom_range(1, 3); k > 0; k--)
                put(8'($urandom_range(255)));
        end
    endtask

    task automatic set_height(input logic [8:0] h);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= h;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    task automatic drain();
        while (bytes_taken != pushed || pending_writes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // sequence of phases
    // ------------------------------------------------------------------
    initial
    begin
        logic [8:0] heights[NUM_PHASES];
        int         send_pcts[NUM_PHASES];
        int         stall_pcts[NUM_PHASES];
        int         base;
        heights    = '{9'd2, 9'd256, 9'd0, 9'd9, 9'd1, 9'd192};
        send_pcts  = '{0, 72, 0, 21, 0, 72};
        stall_pcts = '{0, 0, 72, 21, 0, 72};

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        byte_valid     = 1'b0;
        chunk_type     = '0;
        chunk_start    = 1'b0;
        data_byte      = '0;
        cmd_stall      = 1'b0;
        cfg_height     = FRAME_HEIGHT_RESET;
        clear_decoder();

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // directed: one line of byte-run with a zero run, a literal and a long run
        set_height(9'd1);
        push_seq(CHUNK_BYTERUN, 7, 56'h03_00_11_FF_00_7F_FF);
        // palette skip to the last index, then 64-level colours
        push_seq(CHUNK_PAL256, 7, 56'h01_00_FF_01_E0_1F_FF);
        push_seq(CHUNK_PAL64, 7, 56'h01_00_02_01_3F_38_07);
        // unsupported type, bytes ignored
        push_seq(16'hFFFF, 2, 16'h0C_0F);
        // delta at the last line: address wraps, 128-long run, zero literal
        push_seq(CHUNK_DELTA, 10, 80'hFF_FF_01_00_02_FF_80_AA_00_00);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_height(heights[ph]);
            send_idle_pct = send_pcts[ph];
            stall_pct     = stall_pcts[ph];
            base          = work_items;
            if (ph == 0)
            begin
                // long hold-off on commands while bytes keep coming
                hold_left = HOLD_CYCLES;
                gen_palette(CHUNK_PAL64, 1'b1);
            end
            while (work_items - base < ITEMS_PER_PHASE)
                gen_random_chunk();
            drain();
        end

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
